// ----- design/pstep_pkg.sv -----
// Shared types and constants for the permutation stepper.
// Used by every module under design/ except pstep_ram; depends on nothing.
package pstep_pkg;

	localparam int MAX_LEN = 8;
	localparam int AW      = $clog2(MAX_LEN);
	localparam int ELEM_W  = 8;
	localparam int LEN_W   = 4;
	localparam int POS_W   = 3;
	localparam int KIND_W  = 2;
	// longest run that a step emits
	localparam int ACT_MAX = (MAX_LEN < 8) ? MAX_LEN : 8;
	localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;
	localparam int QDEPTH  = 2;
	localparam int QPW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW     = $clog2(QDEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NEXT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PREV = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_LENGTH = 1'b0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  position;
		logic [ELEM_W-1:0] element_value;
	} item_t;

	typedef struct packed {
		logic [ELEM_W-1:0] out_value;
		logic [POS_W-1:0]  out_position;
		logic              found;
		logic              last;
	} result_t;

	typedef struct packed {
		logic              is_load;
		logic              fwd;
		logic [AW-1:0]     pos;
		logic [ELEM_W-1:0] value;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_REV_RD,
		ST_REV_WA,
		ST_REV_WB,
		ST_EMIT
	} st_t;

endpackage

// ----- design/pstep_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
module pstep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re0,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic                     re1,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re0) begin
			rdata0 <= mem_q[raddr0];
		end
		if (re1) begin
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

// ----- design/pstep_front.sv -----
// Front end: takes items, sorts loads from steps, drops unused kinds,
// and holds them in a short command queue. Depends on pstep_pkg.
module pstep_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pstep_pkg::item_t item,
	output logic             busy,
	output logic             head_valid,
	output pstep_pkg::cmd_t  head,
	input  logic             pop
);

	pstep_pkg::cmd_t ent_q [pstep_pkg::QDEPTH];
	logic [pstep_pkg::QPW-1:0] wr_ptr_q;
	logic [pstep_pkg::QPW-1:0] rd_ptr_q;
	logic [pstep_pkg::QCW-1:0] cnt_q;

	pstep_pkg::cmd_t cmd_new;
	logic            keep;
	logic            push;

	always_comb begin
		cmd_new.is_load = (item.kind == pstep_pkg::KIND_LOAD);
		cmd_new.fwd     = (item.kind == pstep_pkg::KIND_NEXT);
		cmd_new.pos     = pstep_pkg::AW'(item.position);
		cmd_new.value   = item.element_value;
		keep = 1'b0;
		unique case (item.kind)
			pstep_pkg::KIND_LOAD: keep = (int'(item.position) < pstep_pkg::MAX_LEN);
			pstep_pkg::KIND_NEXT: keep = 1'b1;
			pstep_pkg::KIND_PREV: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign busy       = (cnt_q == pstep_pkg::QCW'(pstep_pkg::QDEPTH));
	assign push       = start && !busy && keep;
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_ptr_q];

	function automatic logic [pstep_pkg::QPW-1:0] ptr_inc(input logic [pstep_pkg::QPW-1:0] p);
		ptr_inc = (p == pstep_pkg::QPW'(pstep_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cmd_new;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pstep_pkg::QCW'(pstep_pkg::QDEPTH))
		else $error("command queue count over depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty command queue");

endmodule

// ----- design/pstep_back.sv -----
// Back end: sequencer over the element RAM that runs loads and
// next/prev steps and streams the array out. Depends on pstep_pkg, pstep_ram.
module pstep_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pstep_pkg::LEN_W-1:0] length_in_use,
	input  logic                        head_valid,
	input  pstep_pkg::cmd_t             head,
	output logic                        pop,
	output logic                        res_valid,
	output pstep_pkg::result_t          result
);

	localparam int AW = pstep_pkg::AW;
	localparam int EW = pstep_pkg::ELEM_W;

	pstep_pkg::st_t state_q, state_d;

	logic          fwd_q, found_q, have_prev_q;
	logic [AW-1:0] nm1_q, piv_q, pick_q, lo_q, hi_q;
	logic [EW-1:0] pv_q, pk_q, prev_q;
	logic [AW-1:0] iss_q;
	logic          iss_v_q;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_v_s1;
	logic [pstep_pkg::MAX_LEN-1:0] valid_q;
	logic          v0_s1, v1_s1;

	logic          we, re0, re1;
	logic [AW-1:0] waddr, raddr0, raddr1;
	logic [EW-1:0] wdata, rdata0, rdata1, d0, d1;
	logic [AW-1:0] nm1_new;
	logic          hit_scan, hit_pick, stream;

	pstep_ram #(.WIDTH(EW), .DEPTH(pstep_pkg::MAX_LEN)) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re0    (re0),
		.raddr0 (raddr0),
		.rdata0 (rdata0),
		.re1    (re1),
		.raddr1 (raddr1),
		.rdata1 (rdata1)
	);

	// entries never written read as zero
	assign d0 = v0_s1 ? rdata0 : '0;
	assign d1 = v1_s1 ? rdata1 : '0;

	assign hit_scan = have_prev_q && (fwd_q ? (d0 < prev_q) : (prev_q < d0));
	assign hit_pick = fwd_q ? (pv_q < d0) : (d0 < pv_q);
	assign stream   = (state_q == pstep_pkg::ST_SCAN) || (state_q == pstep_pkg::ST_PICK) ||
	                  (state_q == pstep_pkg::ST_EMIT);

	always_comb begin
		if (length_in_use == '0) begin
			nm1_new = '0;
		end else if (int'(length_in_use) > pstep_pkg::ACT_MAX) begin
			nm1_new = AW'(pstep_pkg::ACT_MAX - 1);
		end else begin
			nm1_new = AW'(length_in_use - 1'b1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pstep_pkg::ST_IDLE: begin
				if (head_valid && !head.is_load) state_d = pstep_pkg::ST_SCAN;
			end
			pstep_pkg::ST_SCAN: begin
				if (rd_v_s1) begin
					if (hit_scan) state_d = pstep_pkg::ST_PICK;
					else if (rd_idx_s1 == '0) state_d = pstep_pkg::ST_EMIT;
				end
			end
			pstep_pkg::ST_PICK: begin
				if (rd_v_s1 && hit_pick) state_d = pstep_pkg::ST_SWAP_A;
			end
			pstep_pkg::ST_SWAP_A: state_d = pstep_pkg::ST_SWAP_B;
			pstep_pkg::ST_SWAP_B: state_d = pstep_pkg::ST_REV_RD;
			pstep_pkg::ST_REV_RD: begin
				state_d = (lo_q < hi_q) ? pstep_pkg::ST_REV_WA : pstep_pkg::ST_EMIT;
			end
			pstep_pkg::ST_REV_WA: state_d = pstep_pkg::ST_REV_WB;
			pstep_pkg::ST_REV_WB: state_d = pstep_pkg::ST_REV_RD;
			pstep_pkg::ST_EMIT: begin
				if (rd_v_s1 && rd_idx_s1 == nm1_q) state_d = pstep_pkg::ST_IDLE;
			end
			default: state_d = pstep_pkg::ST_IDLE;
		endcase
	end

	// RAM controls and outputs
	always_comb begin
		pop    = 1'b0;
		we     = 1'b0;
		waddr  = head.pos;
		wdata  = head.value;
		re0    = 1'b0;
		raddr0 = iss_q;
		re1    = 1'b0;
		raddr1 = hi_q;
		unique case (state_q)
			pstep_pkg::ST_IDLE: begin
				pop = head_valid;
				we  = head_valid && head.is_load;
			end
			pstep_pkg::ST_SCAN, pstep_pkg::ST_PICK, pstep_pkg::ST_EMIT: begin
				re0 = iss_v_q;
			end
			pstep_pkg::ST_SWAP_A: begin
				we    = 1'b1;
				waddr = piv_q;
				wdata = pk_q;
			end
			pstep_pkg::ST_SWAP_B: begin
				we    = 1'b1;
				waddr = pick_q;
				wdata = pv_q;
			end
			pstep_pkg::ST_REV_RD: begin
				re0    = (lo_q < hi_q);
				re1    = (lo_q < hi_q);
				raddr0 = lo_q;
			end
			pstep_pkg::ST_REV_WA: begin
				we    = 1'b1;
				waddr = lo_q;
				wdata = d1;
			end
			pstep_pkg::ST_REV_WB: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = d0;
			end
			default: ;
		endcase
		res_valid           = rd_v_s1 && (state_q == pstep_pkg::ST_EMIT);
		result.out_value    = d0;
		result.out_position = pstep_pkg::POS_W'(rd_idx_s1);
		result.found        = found_q;
		result.last         = (rd_idx_s1 == nm1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pstep_pkg::ST_IDLE;
			rd_v_s1     <= 1'b0;
			iss_v_q     <= 1'b0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= re0 && stream && (state_d == state_q);
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (state_d != state_q &&
			    (state_d == pstep_pkg::ST_SCAN || state_d == pstep_pkg::ST_PICK ||
			     state_d == pstep_pkg::ST_EMIT)) begin
				iss_v_q <= 1'b1;
			end else if (stream && iss_v_q) begin
				if (state_q == pstep_pkg::ST_EMIT) iss_v_q <= (iss_q != nm1_q);
				else iss_v_q <= (iss_q != '0);
			end
			if (state_q == pstep_pkg::ST_IDLE && head_valid && !head.is_load) begin
				have_prev_q <= 1'b0;
				found_q     <= 1'b0;
			end else if (state_q == pstep_pkg::ST_SCAN && rd_v_s1) begin
				if (hit_scan) found_q <= 1'b1;
				else have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re0) begin
			v0_s1 <= valid_q[raddr0];
		end
		if (re1) begin
			v1_s1 <= valid_q[raddr1];
		end
		rd_idx_s1 <= iss_q;
		// read address stream: down from the end while scanning and searching, up while emitting
		if (state_d != state_q && state_d == pstep_pkg::ST_SCAN) begin
			iss_q <= nm1_new;
		end else if (state_d != state_q && state_d == pstep_pkg::ST_PICK) begin
			iss_q <= nm1_q;
		end else if (state_d != state_q && state_d == pstep_pkg::ST_EMIT) begin
			iss_q <= '0;
		end else if (stream && iss_v_q) begin
			if (state_q == pstep_pkg::ST_EMIT) begin
				if (iss_q != nm1_q) iss_q <= iss_q + 1'b1;
			end else if (iss_q != '0) begin
				iss_q <= iss_q - 1'b1;
			end
		end
		if (state_q == pstep_pkg::ST_IDLE && head_valid && !head.is_load) begin
			fwd_q <= head.fwd;
			nm1_q <= nm1_new;
		end
		if (state_q == pstep_pkg::ST_SCAN && rd_v_s1) begin
			if (hit_scan) begin
				piv_q <= rd_idx_s1;
				pv_q  <= d0;
			end else begin
				prev_q <= d0;
			end
		end
		if (state_q == pstep_pkg::ST_PICK && rd_v_s1 && hit_pick) begin
			pick_q <= rd_idx_s1;
			pk_q   <= d0;
		end
		if (state_q == pstep_pkg::ST_SWAP_B) begin
			lo_q <= piv_q + 1'b1;
			hi_q <= nm1_q;
		end else if (state_q == pstep_pkg::ST_REV_WB) begin
			lo_q <= lo_q + 1'b1;
			hi_q <= hi_q - 1'b1;
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result.last |=> state_q == pstep_pkg::ST_IDLE)
		else $error("emit did not end on last beat");

	a_rev_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pstep_pkg::ST_REV_WA || state_q == pstep_pkg::ST_REV_WB) |-> lo_q < hi_q)
		else $error("suffix reversal pointers crossed");

	a_swap_pick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pstep_pkg::ST_SWAP_A |-> found_q && (pick_q > piv_q))
		else $error("swap without valid pivot and pick");

endmodule

// ----- design/permutation_stepper_core.sv -----
// Permutation stepper top level: configuration register, front end and
// back end. Depends on pstep_pkg, pstep_front, pstep_back.
//
// Usage:
//  - Items enter on start/item, taken at an edge where start is high and busy
//    is low. kind 0 loads element_value at position; kind 1 steps to the next
//    lexicographic permutation, kind 2 to the previous one; kind 3 is ignored.
//  - A step emits n = length_in_use elements (clamped to 1..8) as n result
//    beats on consecutive cycles, each marked by res_valid for one cycle, in
//    position order, with found and last. The receiver cannot stall.
//  - Items queue in a two-entry command queue; busy is high while it is full.
//  - A load is written to the element RAM from the idle state. A step scans
//    the array one RAM read per cycle, searches the swap element, swaps,
//    reverses the suffix pair by pair, then emits; with no pivot it goes
//    straight from the scan to the emit. The element RAM has a single write
//    port, so the swap and each reversed pair take one write per element.
//  - length_in_use is at APB address 0 and resets to 8. Write it only while
//    the block is idle.
//  - Reset clears the array to zeros (per-entry valid bits) and the queue.
module permutation_stepper_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  pstep_pkg::item_t            item,
	output logic                        busy,
	output logic                        res_valid,
	output pstep_pkg::result_t          result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [pstep_pkg::LEN_W-1:0] len_q;
	logic                        cfg_wr;
	logic                        head_valid;
	logic                        pop;
	pstep_pkg::cmd_t             head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= pstep_pkg::LEN_RESET;
		end else if (cfg_wr && paddr[2] == pstep_pkg::REG_LENGTH) begin
			len_q <= pwdata[pstep_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pstep_pkg::REG_LENGTH) begin
			prdata = 32'(len_q);
		end
	end

	pstep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pstep_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.length_in_use (len_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.res_valid     (res_valid),
		.result        (result)
	);

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for permutation_stepper_core: loads arrays, steps
// them forward and back, and checks every emitted element beat against an
// in-bench model. Depends on pstep_pkg and the design.
module tb_top;
	import pstep_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // unused kind, dropped by the block
	localparam logic [2:0] LEN_ADDR   = {REG_LENGTH, 2'b00};
	localparam logic [2:0] SPARE_ADDR = {~REG_LENGTH, 2'b00};
	localparam int DRAIN_CYCLES = 60;                  // longest step plus queued loads
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	item_t       item;
	logic        busy;
	logic        res_valid;
	result_t     result;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	permutation_stepper_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.res_valid(res_valid), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// model state
	logic [ELEM_W-1:0] perm_elems [MAX_LEN];
	logic [LEN_W-1:0]  len_reg;
	result_t           pending_beats [$];

	int mismatches;
	int cycle_count;
	int step_items;
	int burst_left;
	bit gaps_on;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				pending_beats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int active_len();
		int n;
		n = int'(len_reg);
		if (n < 1) n = 1;
		if (n > ACT_MAX) n = ACT_MAX;
		return n;
	endfunction

	// next/prev lexicographic step; queues one beat per element in use
	function automatic void step_array(input bit fwd);
		int n, pivot, pick, lo, hi;
		bit have_pivot, have_pick;
		logic [ELEM_W-1:0] t;
		result_t r;
		n = active_len();
		pivot = 0;
		pick = 0;
		have_pivot = 1'b0;
		have_pick = 1'b0;
		for (int i = 1; i < n; i++) begin
			if (fwd ? (perm_elems[i-1] < perm_elems[i])
			        : (perm_elems[i] < perm_elems[i-1])) begin
				pivot = i - 1;
				have_pivot = 1'b1;
			end
		end
		if (have_pivot) begin
			for (int i = pivot + 1; i < n; i++) begin
				if (fwd ? (perm_elems[pivot] < perm_elems[i])
				        : (perm_elems[i] < perm_elems[pivot])) begin
					pick = i;
					have_pick = 1'b1;
				end
			end
			if (have_pick) begin
				t = perm_elems[pivot];
				perm_elems[pivot] = perm_elems[pick];
				perm_elems[pick] = t;
				lo = pivot + 1;
				hi = n - 1;
				while (lo < hi) begin
					t = perm_elems[lo];
					perm_elems[lo] = perm_elems[hi];
					perm_elems[hi] = t;
					lo++;
					hi--;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			r.out_value    = perm_elems[k];
			r.out_position = POS_W'(k);
			r.found        = have_pivot;
			r.last         = (k == n - 1);
			pending_beats.push_back(r);
		end
	endfunction

	function automatic void apply_item(input item_t it);
		case (it.kind)
			KIND_LOAD: perm_elems[it.position] = it.element_value;
			KIND_NEXT: step_array(1'b1);
			KIND_PREV: step_array(1'b0);
			default: ;
		endcase
	endfunction

	// result beat checker; the receiver never stalls
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1) begin
			if (pending_beats.size() == 0) begin
				if (mismatches < 10)
					$display("cycle %0d: unexpected beat val=%h pos=%0d found=%b last=%b",
						cycle_count, result.out_value, result.out_position, result.found,
						result.last);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (result.out_value !== want.out_value
					|| result.out_position !== want.out_position
					|| result.found !== want.found || result.last !== want.last) begin
					if (mismatches < 10) begin
						$display("cycle %0d: beat mismatch exp val=%h pos=%0d found=%b last=%b",
							cycle_count, want.out_value, want.out_position, want.found,
							want.last);
						$display("    got val=%h pos=%0d found=%b last=%b",
							result.out_value, result.out_position, result.found,
							result.last);
					end
					mismatches++;
				end
			end
		end
	end

	// start stays high after acceptance; the caller either sends again or lowers it
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [ELEM_W-1:0] val);
		item_t it;
		int gap;
		it.kind = kind;
		it.position = pos;
		it.element_value = val;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) burst_left--;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		apply_item(it);
		if (kind != KIND_NONE) step_items++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write then read back; only legal once drained
	task automatic write_length(input logic [2:0] addr, input logic [LEN_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {8'($urandom_range(0, 255)), 20'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == LEN_ADDR) len_reg = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= LEN_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[LEN_W-1:0] !== len_reg) begin
			if (mismatches < 10)
				$display("length readback exp %0d got %0d", len_reg, prdata[LEN_W-1:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_contents();
		// all-zero array: duplicates everywhere, no pivot either way
		send_item(KIND_NEXT, 3'd0, 8'h00);
		send_item(KIND_PREV, 3'd7, 8'hFF);
		drain();
	endtask

	task automatic test_extreme_values();
		logic [ELEM_W-1:0] vals [MAX_LEN];
		vals = '{8'h00, 8'h80, 8'h7F, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'hFE};
		for (int p = 0; p < MAX_LEN; p++) send_item(KIND_LOAD, POS_W'(p), vals[p]);
		send_item(KIND_NEXT, 3'd0, 8'h00);
		send_item(KIND_NONE, 3'd5, 8'hFF);
		send_item(KIND_PREV, 3'd2, 8'h00);
		drain();
	endtask

	task automatic test_length_extremes();
		write_length(LEN_ADDR, 4'd1);
		send_item(KIND_NEXT, 3'd0, 8'h00);
		drain();
		write_length(LEN_ADDR, 4'd0);      // behaves as one element
		send_item(KIND_PREV, 3'd0, 8'h00);
		drain();
		write_length(LEN_ADDR, 4'd15);     // saturates to the full array
		write_length(SPARE_ADDR, 4'd2);    // no register there
		send_item(KIND_NEXT, 3'd0, 8'h00);
		drain();
	endtask

	task automatic test_last_and_first();
		write_length(LEN_ADDR, 4'd3);
		// descending: next has no pivot, prev does
		send_item(KIND_LOAD, 3'd0, 8'hFF);
		send_item(KIND_LOAD, 3'd1, 8'h80);
		send_item(KIND_LOAD, 3'd2, 8'h00);
		send_item(KIND_NEXT, 3'd0, 8'h00);
		send_item(KIND_PREV, 3'd0, 8'h00);
		// ascending with a repeated value: prev has no pivot
		send_item(KIND_LOAD, 3'd0, 8'h00);
		send_item(KIND_LOAD, 3'd1, 8'h00);
		send_item(KIND_LOAD, 3'd2, 8'h01);
		send_item(KIND_PREV, 3'd0, 8'h00);
		drain();
	endtask

	// load the active elements, then walk a few steps mostly one way
	task automatic run_walk();
		int n, steps;
		bit fwd, narrow;
		logic [ELEM_W-1:0] base;
		n = active_len();
		narrow = 1'($urandom_range(0, 1));
		base = ELEM_W'($urandom_range(0, 252));
		for (int p = 0; p < n; p++)
			send_item(KIND_LOAD, POS_W'(p),
				narrow ? base + ELEM_W'($urandom_range(0, 3)) : ELEM_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0)
			send_item(KIND_LOAD, POS_W'($urandom_range(0, MAX_LEN - 1)),
				ELEM_W'($urandom_range(0, 255)));
		fwd = 1'($urandom_range(0, 1));
		steps = $urandom_range(1, 8);
		for (int s = 0; s < steps; s++) begin
			if ($urandom_range(0, 4) == 0) fwd = !fwd;
			send_item(fwd ? KIND_NEXT : KIND_PREV, POS_W'($urandom_range(0, MAX_LEN - 1)),
				ELEM_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_walks();
		logic [LEN_W-1:0] lens [11];
		int phase_start;
		lens = '{4'd2, 4'd3, 4'd8, 4'd1, 4'd5, 4'd0, 4'd15, 4'd4, 4'd6, 4'd7, 4'd9};
		for (int ph = 0; ph < 11; ph++) begin
			write_length(LEN_ADDR, lens[ph]);
			gaps_on = (ph != 0) && ($urandom_range(0, 4) != 0);
			burst_left = 0;
			phase_start = step_items;
			while (step_items - phase_start < 17) begin
				if ($urandom_range(0, 3) != 0)
					run_walk();
				else
					send_item(KIND_W'($urandom_range(0, 3)),
						POS_W'($urandom_range(0, MAX_LEN - 1)),
						ELEM_W'($urandom_range(0, 255)));
				// hold off mid-phase until all beats are back
				if (ph == 4 && step_items - phase_start >= 11 && step_items - phase_start < 14)
					drain();
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		cycle_count = 0;
		step_items = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		len_reg = LEN_RESET;
		for (int p = 0; p < MAX_LEN; p++) perm_elems[p] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_extreme_values();
		test_length_extremes();
		test_last_and_first();
		test_random_walks();

		drain();
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/pstep_pkg.sv
design/pstep_ram.sv
design/pstep_front.sv
design/pstep_back.sv
design/permutation_stepper_core.sv
dv/tb_top.sv
